FILE: rtl/core/sibp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the spanning index bit packer.
// No dependencies; imported by every module of the block.
package sibp_pkg;

  localparam int unsigned WordBits    = 64;
  localparam int unsigned IdxBits     = 16;
  localparam int unsigned SizeBits    = 17;
  // Holds any index width up to the index port width IdxBits (16).
  localparam int unsigned WidthBits   = 6;
  localparam int unsigned FillBits    = 6;
  localparam logic [WidthBits-1:0] MinWidth = WidthBits'(2);

  // One classified item: masked index, its width and the final flag.
  typedef struct packed {
    logic [IdxBits-1:0]   idx;
    logic [WidthBits-1:0] width;
    logic                 fin;
  } sibp_entry_t;

  // One result word waiting for the output side.
  typedef struct packed {
    logic [WordBits-1:0] word;
    logic                last;
  } sibp_word_t;

endpackage

FILE: rtl/core/spanning_index_bit_packer.sv
`timescale 1ns / 1ps
// An accepted index goes through the queue and then the output register.
// Throughput: one index per cycle while in_stall_o is low; an index that both
// fills a word and flushes a final partial word parks the second in a spare slot.
// Reset: palette width back to 2 bits, accumulator and fill empty, queue empty,
// no output valid. Top level; uses sibp_pkg, sibp_front, sibp_queue, sibp_back.
module spanning_index_bit_packer #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          palette_size_we_i,
  input  logic [sibp_pkg::SizeBits-1:0] palette_size_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sibp_pkg::IdxBits-1:0]  palette_index_i,
  input  logic                          final_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sibp_pkg::WordBits-1:0] packed_word_o,
  output logic                          last_word_o
);
  import sibp_pkg::*;

  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  sibp_entry_t push_entry;
  sibp_entry_t head_entry;

  sibp_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .palette_size_we_i (palette_size_we_i),
    .palette_size_i    (palette_size_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .palette_index_i   (palette_index_i),
    .final_item_i      (final_item_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .entry_o           (push_entry)
  );

  sibp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  sibp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packed_word_o (packed_word_o),
    .last_word_o   (last_word_o)
  );

endmodule

FILE: rtl/core/sibp_front.sv
`timescale 1ns / 1ps
// Front end: holds the palette width setting, masks each index to it and
// pushes the classified transaction into the queue. Depends on sibp_pkg.
module sibp_front #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         palette_size_we_i,
  input  logic [sibp_pkg::SizeBits-1:0] palette_size_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sibp_pkg::IdxBits-1:0] palette_index_i,
  input  logic                         final_item_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output sibp_pkg::sibp_entry_t        entry_o
);
  import sibp_pkg::*;

  localparam logic [WidthBits-1:0] MaxWidth = WidthBits'(INDEX_BITS);

  logic [WidthBits-1:0] width_q, width_d;
  logic [SizeBits-1:0]  size_m1;
  logic [WidthBits-1:0] bit_len;
  logic [IdxBits-1:0]   mask;

  // Bit length of (size - 1) is ceil(log2(size)); size zero counts as one.
  always_comb begin
    size_m1 = (palette_size_i != '0) ? palette_size_i - SizeBits'(1) : '0;
    bit_len = '0;
    for (int i = 0; i < SizeBits; i++) begin
      if (size_m1[i]) begin
        bit_len = WidthBits'(i + 1);
      end
    end
  end

  always_comb begin
    width_d = width_q;
    if (palette_size_we_i) begin
      if (bit_len > MaxWidth) begin
        width_d = MaxWidth;
      end else if (bit_len < MinWidth) begin
        width_d = MinWidth;
      end else begin
        width_d = bit_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= MinWidth;
    end else begin
      width_q <= width_d;
    end
  end

  always_comb begin
    for (int i = 0; i < IdxBits; i++) begin
      mask[i] = (WidthBits'(i) < width_q);
    end
  end

  assign in_stall_o    = q_full_i;
  assign push_o        = in_valid_i & ~q_full_i;
  assign entry_o.idx   = palette_index_i & mask;
  assign entry_o.width = width_q;
  assign entry_o.fin   = final_item_i;

endmodule

FILE: rtl/core/sibp_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified transactions between front and back end.
// Depends on sibp_pkg for the entry type.
module sibp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sibp_pkg::sibp_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output sibp_pkg::sibp_entry_t entry_o
);
  import sibp_pkg::*;

  sibp_entry_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign full_o  = count_q[1];
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

endmodule

FILE: rtl/core/sibp_back.sv
`timescale 1ns / 1ps
// Back end: shifts each index into the 64-bit accumulator, emits full and
// flushed words through an output register and a spare word slot. Uses sibp_pkg.
module sibp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  sibp_pkg::sibp_entry_t         entry_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sibp_pkg::WordBits-1:0] packed_word_o,
  output logic                          last_word_o
);
  import sibp_pkg::*;

  logic [WordBits-1:0]   acc_q, acc_d;
  logic [FillBits-1:0]   fill_q, fill_d;
  logic                  out_valid_q, out_valid_d;
  sibp_word_t            out_q, out_d;
  logic                  pend_valid_q, pend_valid_d;
  sibp_word_t            pend_q, pend_d;

  logic [2*WordBits-1:0] shifted;
  logic [WordBits-1:0]   acc_or, acc_n;
  logic [FillBits:0]     sum;
  logic                  word_full;
  logic [FillBits-1:0]   fill_n;
  logic                  have0, have1;
  sibp_word_t            res0, res1;
  logic                  slot_free;

  // Upper half of the wide shift is the part of the index that spills over.
  always_comb begin
    shifted   = {{(2*WordBits-IdxBits){1'b0}}, entry_i.idx} << fill_q;
    acc_or    = acc_q | shifted[WordBits-1:0];
    sum       = {1'b0, fill_q} + (FillBits+1)'(entry_i.width);
    word_full = sum[FillBits];
    fill_n    = sum[FillBits-1:0];
    acc_n     = word_full ? shifted[2*WordBits-1:WordBits] : acc_or;

    have0      = word_full | entry_i.fin;
    res0.word  = word_full ? acc_or : acc_n;
    res0.last  = entry_i.fin & (~word_full | (fill_n == '0));
    have1      = word_full & entry_i.fin & (fill_n != '0);
    res1.word  = acc_n;
    res1.last  = 1'b1;
  end

  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign pop_o     = q_valid_i & ~pend_valid_q & slot_free;

  always_comb begin
    acc_d        = acc_q;
    fill_d       = fill_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;

    if (pop_o) begin
      // Restart the stream after a final transaction.
      acc_d  = entry_i.fin ? '0 : acc_n;
      fill_d = entry_i.fin ? '0 : fill_n;
    end

    if (slot_free) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = pend_q;
        pend_valid_d = 1'b0;
      end else if (pop_o) begin
        out_valid_d  = have0;
        out_d        = res0;
        pend_valid_d = have1;
        pend_d       = res1;
      end else begin
        out_valid_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      acc_q        <= acc_d;
      fill_q       <= fill_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o   = out_valid_q;
  assign packed_word_o = out_q.word;
  assign last_word_o   = out_q.last;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the spanning index bit packer: directed rows, then random streams.
// Predicts packed words in-bench and scoreboards every output transaction.
// Depends on sibp_pkg and spanning_index_bit_packer.
module tb_top;
  import sibp_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic                do_cfg;
    logic [SizeBits-1:0] size;
    logic [IdxBits-1:0]  idx;
    logic                fin;
    logic                typed;
    logic [WordBits-1:0] word;
    logic                last;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                palette_size_we_i;
  logic [SizeBits-1:0] palette_size_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [IdxBits-1:0]  palette_index_i;
  logic                final_item_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [WordBits-1:0] packed_word_o;
  logic                last_word_o;

  // Shadow of the block state
  logic [SizeBits-1:0] size_shadow;
  logic [WordBits-1:0] acc_shadow;
  int unsigned         fill_shadow;

  sibp_word_t  pending_words[$];
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  dir_row_t directed_rows[21];

  spanning_index_bit_packer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .palette_size_we_i (palette_size_we_i),
    .palette_size_i    (palette_size_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .palette_index_i   (palette_index_i),
    .final_item_i      (final_item_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .packed_word_o     (packed_word_o),
    .last_word_o       (last_word_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned index_width(input logic [SizeBits-1:0] size);
    logic [SizeBits-1:0] v;
    int unsigned w;
    v = (size != '0) ? size - 1'b1 : '0;
    w = 0;
    while (v != '0) begin
      w++;
      v = v >> 1;
    end
    if (w < 2) w = 2;
    if (w > IdxBits) w = IdxBits;
    return w;
  endfunction

  // Advance the shadow packer by one index; return the words it completes.
  function automatic int pack_index(input logic [IdxBits-1:0] idx, input logic fin,
                                    output sibp_word_t r0, output sibp_word_t r1);
    int unsigned w;
    logic [WordBits-1:0] masked;
    int n;
    w = index_width(size_shadow);
    masked = WordBits'(idx) & ((64'd1 << w) - 64'd1);
    n = 0;
    r0 = '0;
    r1 = '0;
    acc_shadow = acc_shadow | (masked << fill_shadow);
    if (fill_shadow + w >= WordBits) begin
      r0 = '{word: acc_shadow, last: 1'b0};
      n = 1;
      acc_shadow = masked >> (WordBits - fill_shadow);
      fill_shadow = fill_shadow + w - WordBits;
    end else begin
      fill_shadow = fill_shadow + w;
    end
    if (fin) begin
      if (fill_shadow != 0) begin
        if (n == 0) r0 = '{word: acc_shadow, last: 1'b1};
        else r1 = '{word: acc_shadow, last: 1'b1};
        n++;
      end else if (n > 0) begin
        r0.last = 1'b1;
      end
      acc_shadow = '0;
      fill_shadow = 0;
    end
    return n;
  endfunction

  function automatic void report_mismatch(input string what, input logic [WordBits-1:0] exp_v,
                                          input logic [WordBits-1:0] act_v);
    fail_count++;
    if (fail_count <= MaxReports)
      $display("mismatch %s: expected %h, got %h at %0t", what, exp_v, act_v, $realtime);
  endfunction

  // Append one word to the expected queue.
  function automatic void expect_word(input sibp_word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Sit idle until every expected word is out and the pipeline has settled.
  task automatic drain_pipeline();
    in_valid_i = 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_palette_size(input logic [SizeBits-1:0] size);
    drain_pipeline();
    palette_size_we_i = 1'b1;
    palette_size_i = size;
    @(negedge clk_i);
    palette_size_we_i = 1'b0;
    size_shadow = size;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_index(input logic [IdxBits-1:0] idx, input logic fin, input logic typed,
                            input sibp_word_t typed_word);
    sibp_word_t r0, r1;
    int n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    palette_index_i = idx;
    final_item_i = fin;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    n = pack_index(idx, fin, r0, r1);
    if (typed) begin
      expect_word(typed_word);
    end else begin
      if (n > 0) expect_word(r0);
      if (n > 1) expect_word(r1);
    end
    @(negedge clk_i);
  endtask

  function automatic logic [SizeBits-1:0] draw_palette_size();
    int unsigned k;
    case ($urandom_range(0, 3))
      0: return SizeBits'($urandom_range(0, 2));
      1: return SizeBits'($urandom_range(65536, 131071));
      2: return SizeBits'($urandom_range(0, 131071));
      default: begin
        k = $urandom_range(1, 16);
        return SizeBits'((1 << k) + $urandom_range(0, 1));
      end
    endcase
  endfunction

  function automatic logic [IdxBits-1:0] draw_index();
    int unsigned top;
    if ($urandom_range(0, 4) == 0) return IdxBits'($urandom);
    top = (size_shadow > 65536) ? 65535 : ((size_shadow > 0) ? size_shadow - 1 : 0);
    return IdxBits'($urandom_range(0, top));
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Scoreboard: compare each output transaction against the oldest expected word.
  always @(posedge clk_i) begin
    sibp_word_t head;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", '0, packed_word_o);
      end else begin
        head = pending_words.pop_front();
        if (packed_word_o !== head.word) report_mismatch("packed_word", head.word, packed_word_o);
        if (last_word_o !== head.last)
          report_mismatch("last_word", WordBits'(head.last), WordBits'(last_word_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned items;
    directed_rows = '{
      // reset width, index masked to 2 bits
      '{1'b0, 17'd0,      16'hFFFF, 1'b1, 1'b1, 64'h3, 1'b1},
      '{1'b1, 17'd0,      16'h0002, 1'b1, 1'b1, 64'h2, 1'b1},
      '{1'b1, 17'd65536,  16'hFFFF, 1'b1, 1'b1, 64'hFFFF, 1'b1},
      // width saturates at 16
      '{1'b1, 17'd131071, 16'hABCD, 1'b1, 1'b1, 64'hABCD, 1'b1},
      '{1'b1, 17'd65537,  16'h1234, 1'b0, 1'b0, 64'h0, 1'b0},
      '{1'b0, 17'd0,      16'h5678, 1'b0, 1'b0, 64'h0, 1'b0},
      '{1'b0, 17'd0,      16'h9ABC, 1'b0, 1'b0, 64'h0, 1'b0},
      // final index lands exactly on the word boundary
      '{1'b0, 17'd0,      16'hDEF0, 1'b1, 1'b1, 64'hDEF09ABC56781234, 1'b1},
      '{1'b1, 17'd3,      16'hFFFF, 1'b1, 1'b1, 64'h3, 1'b1},
      // 12-bit indices: the sixth one spans two words
      '{1'b1, 17'd4096,   16'h0FFF, 1'b0, 1'b0, 64'h0, 1'b0},
      '{1'b0, 17'd0,      16'h0FFF, 1'b0, 1'b0, 64'h0, 1'b0},
      '{1'b0, 17'd0,      16'h0FFF, 1'b0, 1'b0, 64'h0, 1'b0},
      '{1'b0, 17'd0,      16'h0FFF, 1'b0, 1'b0, 64'h0, 1'b0},
      '{1'b0, 17'd0,      16'h0FFF, 1'b0, 1'b0, 64'h0, 1'b0},
      '{1'b0, 17'd0,      16'h0FFF, 1'b1, 1'b0, 64'h0, 1'b0},
      // width changes in the middle of a stream
      '{1'b1, 17'd256,    16'h01AA, 1'b0, 1'b0, 64'h0, 1'b0},
      '{1'b1, 17'd65536,  16'hBEEF, 1'b1, 1'b0, 64'h0, 1'b0},
      '{1'b1, 17'd2,      16'h0000, 1'b1, 1'b1, 64'h0, 1'b1},
      '{1'b1, 17'd65535,  16'h0000, 1'b1, 1'b1, 64'h0, 1'b1},
      '{1'b1, 17'd17,     16'h001F, 1'b0, 1'b0, 64'h0, 1'b0},
      '{1'b0, 17'd0,      16'h0000, 1'b1, 1'b0, 64'h0, 1'b0}
    };
    rst_ni = 1'b0;
    palette_size_we_i = 1'b0;
    palette_size_i = '0;
    in_valid_i = 1'b0;
    palette_index_i = '0;
    final_item_i = 1'b0;
    fail_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 26;
    recv_idle_pct = 65;
    size_shadow = 17'd1;
    acc_shadow = '0;
    fill_shadow = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].do_cfg) write_palette_size(directed_rows[i].size);
      push_index(directed_rows[i].idx, directed_rows[i].fin, directed_rows[i].typed,
                 '{word: directed_rows[i].word, last: directed_rows[i].last});
    end

    // Swap idle ratios, then run flat out; each segment starts from an idle block.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : ((phase == 1) ? 65 : 0);
      recv_idle_pct = (phase == 0) ? 65 : ((phase == 1) ? 26 : 0);
      for (int seg = 0; seg < 10; seg++) begin
        write_palette_size(draw_palette_size());
        items = $urandom_range(10, 47);
        for (int k = 0; k < items; k++)
          push_index(draw_index(), ($urandom_range(0, 19) == 0), 1'b0, '0);
      end
    end

    drain_pipeline();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
